// File: hw/rtl/rdq_pkg.sv
// shared types and constants for the reversible deque unit
`default_nettype none

package rdq_pkg;

    localparam int DEPTH  = 1024;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SUM_W  = CNT_W + 1;
    localparam int WORD_W = 32;

    typedef enum logic [2:0] {
        OP_POP_BACK   = 3'd0,
        OP_POP_FRONT  = 3'd1,
        OP_REVERSE    = 3'd2,
        OP_PUSH_BACK  = 3'd3,
        OP_PUSH_FRONT = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_DONE  = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    typedef struct packed {
        op_t                       op;
        logic signed [WORD_W-1:0]  value;
    } rdq_in_t;

    typedef struct packed {
        logic signed [WORD_W-1:0]  popped_value;
        status_t                   status;
    } rdq_out_t;

endpackage

`default_nettype wire

// File: hw/rtl/rdq_ram.sv
// single-port-per-direction synchronous ring memory, registered read
`default_nettype none

module rdq_ram #(
    parameter int DEPTH  = 1024,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/reversible_deque_unit.sv
// reversible deque: a two-ended queue of 32-bit words in a ring memory with a reverse flag
// timing: the memory read is registered at the accepting edge, and the pending stage moves
// into the output register once that is free, which raises m_valid; throughput: one transaction
// per cycle while m_ready keeps the output free, set by the single ring memory access per item
// and the pointer update done at accept time. no clearing pass: the ring is not cleared,
// reset (aresetn, synchronous, active low) empties the queue and clears the reverse flag
`default_nettype none

module reversible_deque_unit
    import rdq_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire rdq_in_t  s_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    output rdq_out_t      m_data
);

    logic [ADDR_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              rev_reg, rev_next;

    logic              pend_valid_reg;
    logic              pend_pop_reg;
    status_t           pend_status_reg;

    logic              out_valid_reg;
    rdq_out_t          out_data_reg;

    logic              out_free;
    logic              pend_move;
    logic              accept;

    logic              is_empty;
    logic              is_full;
    logic              phys_back;
    logic              do_pop;
    logic              do_push;
    status_t           status_c;

    logic [SUM_W-1:0]  sum_tail;
    logic [SUM_W-1:0]  sum_last;
    logic [ADDR_W-1:0] tail_slot;
    logic [ADDR_W-1:0] last_slot;
    logic [ADDR_W-1:0] head_inc;
    logic [ADDR_W-1:0] head_dec;
    logic [ADDR_W-1:0] mem_addr;
    logic [WORD_W-1:0] rd_data;

    assign out_free  = !out_valid_reg || m_ready;
    assign pend_move = pend_valid_reg && out_free;
    assign s_ready   = !pend_valid_reg || out_free;
    assign accept    = s_valid && s_ready;

    assign is_empty = (count_reg == '0);
    assign is_full  = (count_reg == CNT_W'(DEPTH));

    // slot just past the physical back and the physical back itself, modulo depth
    assign sum_tail  = SUM_W'(head_reg) + SUM_W'(count_reg);
    assign sum_last  = sum_tail - SUM_W'(1);
    assign tail_slot = (sum_tail >= SUM_W'(DEPTH)) ? ADDR_W'(sum_tail - SUM_W'(DEPTH))
                                                   : ADDR_W'(sum_tail);
    assign last_slot = (sum_last >= SUM_W'(DEPTH)) ? ADDR_W'(sum_last - SUM_W'(DEPTH))
                                                   : ADDR_W'(sum_last);
    assign head_inc  = (head_reg == ADDR_W'(DEPTH - 1)) ? '0 : head_reg + ADDR_W'(1);
    assign head_dec  = (head_reg == '0) ? ADDR_W'(DEPTH - 1) : head_reg - ADDR_W'(1);

    always_comb begin
        head_next  = head_reg;
        count_next = count_reg;
        rev_next   = rev_reg;
        phys_back  = 1'b0;
        do_pop     = 1'b0;
        do_push    = 1'b0;
        status_c   = ST_DONE;
        mem_addr   = head_reg;
        case (s_data.op)
            OP_POP_BACK, OP_POP_FRONT: begin
                // logical end maps to the opposite physical end while reversed
                phys_back = (s_data.op == OP_POP_BACK) != rev_reg;
                if (is_empty) begin
                    status_c = ST_EMPTY;
                end else begin
                    status_c   = ST_OK;
                    do_pop     = 1'b1;
                    count_next = count_reg - CNT_W'(1);
                    if (phys_back) begin
                        mem_addr = last_slot;
                    end else begin
                        mem_addr  = head_reg;
                        head_next = head_inc;
                    end
                end
            end
            OP_REVERSE: begin
                rev_next = !rev_reg;
            end
            OP_PUSH_BACK, OP_PUSH_FRONT: begin
                phys_back = (s_data.op == OP_PUSH_BACK) != rev_reg;
                if (is_full) begin
                    status_c = ST_FULL;
                end else begin
                    do_push    = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                    if (phys_back) begin
                        mem_addr = tail_slot;
                    end else begin
                        mem_addr  = head_dec;
                        head_next = head_dec;
                    end
                end
            end
            default: begin
                status_c = ST_DONE;
            end
        endcase
    end

    rdq_ram #(
        .DEPTH (DEPTH),
        .WIDTH (WORD_W)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (accept && do_push),
        .wr_addr (mem_addr),
        .wr_data (s_data.value),
        .rd_en   (accept && do_pop),
        .rd_addr (mem_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            count_reg <= '0;
            rev_reg   <= 1'b0;
        end else if (accept) begin
            head_reg  <= head_next;
            count_reg <= count_next;
            rev_reg   <= rev_next;
        end
    end

    // pending stage waits for the registered memory read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
        end else if (accept) begin
            pend_valid_reg <= 1'b1;
        end else if (pend_move) begin
            pend_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            pend_pop_reg    <= do_pop;
            pend_status_reg <= status_c;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (pend_move) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pend_move) begin
            out_data_reg.popped_value <= pend_pop_reg ? rd_data : '0;
            out_data_reg.status       <= pend_status_reg;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

`default_nettype wire
